// ----- hdl/rbcd_pkg.sv -----
// rbcd_pkg: item types, request and status codes, controller-datapath interface types
`timescale 1ns / 1ps

package rbcd_pkg;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int BLOCK_W  = 48;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 4;
    localparam int REFS_W   = 8;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [BLOCK_W-1:0] block_number;
        logic [LEVEL_W-1:0] priority_level;
    } t_req_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
    } t_rsp_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic look;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic commit_ok;
    } t_dp_sts;

endpackage

// ----- hdl/rbcd_ctrl.sv -----
// rbcd_ctrl: request sequencer (accept, look up, commit)
`timescale 1ns / 1ps

module rbcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rbcd_pkg::t_dp_sts i_sts,
    output rbcd_pkg::t_dp_cmd o_cmd
);
    import rbcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOK   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   commit;

    // a new item enters when idle or as the current one commits
    assign commit     = (r_state == S_COMMIT) && i_sts.commit_ok;
    assign o_in_ready = (r_state == S_IDLE) || commit;
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.capture = accept;
    assign o_cmd.look    = (r_state == S_LOOK);
    assign o_cmd.commit  = commit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) n_state = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/rbcd_dpath.sv -----
// rbcd_dpath: slot directory, match and victim search, slot update, result register
`timescale 1ns / 1ps

module rbcd_dpath #(
    parameter int SLOTS     = 16,
    parameter int TOP_LEVEL = 5,
    parameter int TAG_BITS  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbcd_pkg::t_req_item i_in_item,
    input  rbcd_pkg::t_dp_cmd   i_cmd,
    output rbcd_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rbcd_pkg::t_rsp_item o_out_item
);
    import rbcd_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEVELS = 1 << LEVEL_W;

    // captured request
    logic [REQ_W-1:0]    r_req_type;
    logic [TAG_BITS-1:0] r_tag;
    logic [LEVEL_W-1:0]  r_level;

    // slot state
    logic                r_slot_valid [SLOTS];
    logic [TAG_BITS-1:0] r_slot_tag   [SLOTS];
    logic [LEVEL_W-1:0]  r_slot_level [SLOTS];
    logic [REFS_W-1:0]   r_slot_refs  [SLOTS];

    // look-up results
    logic [SLOTS-1:0] r_hit_vec;
    logic [SLOTS-1:0] r_free_vec;
    logic [SLOTS-1:0] r_cand_vec;
    logic [SLOTS-1:0] n_hit_vec;
    logic [SLOTS-1:0] n_free_vec;
    logic [SLOTS-1:0] n_cand_vec;

    logic [LEVELS-1:0]  lvl_any;
    logic [LEVEL_W-1:0] min_lvl;
    logic [LEVEL_W-1:0] req_lvl;

    logic              hit_any;
    logic              free_any;
    logic              cand_any;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] cand_idx;
    logic              alloc_any;
    logic [SLOT_W-1:0] alloc_idx;

    logic      r_out_valid;
    t_rsp_item r_out_item;
    t_rsp_item n_out_item;

    // level clamp at capture
    assign req_lvl = (i_in_item.priority_level > LEVEL_W'(TOP_LEVEL)) ?
                     LEVEL_W'(TOP_LEVEL) : i_in_item.priority_level;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_in_item.req_type;
            r_tag      <= TAG_BITS'(i_in_item.block_number);
            r_level    <= req_lvl;
        end
    end

    // per-slot match, free and unreferenced-level flags
    always_comb begin
        lvl_any = '0;
        for (int s = 0; s < SLOTS; s++) begin
            n_hit_vec[s]  = r_slot_valid[s] && (r_slot_tag[s] == r_tag);
            n_free_vec[s] = !r_slot_valid[s];
            if (r_slot_refs[s] == '0) lvl_any[r_slot_level[s]] = 1'b1;
        end
        // lowest level among unreferenced slots
        min_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (lvl_any[l]) min_lvl = LEVEL_W'(l);
        end
        for (int s = 0; s < SLOTS; s++) begin
            n_cand_vec[s] = (r_slot_refs[s] == '0) && (r_slot_level[s] == min_lvl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit_vec  <= n_hit_vec;
            r_free_vec <= n_free_vec;
            r_cand_vec <= n_cand_vec;
        end
    end

    // lowest-index picks
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        cand_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_hit_vec[s])  hit_idx  = SLOT_W'(s);
            if (r_free_vec[s]) free_idx = SLOT_W'(s);
            if (r_cand_vec[s]) cand_idx = SLOT_W'(s);
        end
        hit_any   = |r_hit_vec;
        free_any  = |r_free_vec;
        cand_any  = |r_cand_vec;
        alloc_any = free_any || cand_any;
        alloc_idx = free_any ? free_idx : cand_idx;
    end

    // slot control state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_slot_valid[s] <= 1'b0;
                r_slot_level[s] <= '0;
                r_slot_refs[s]  <= '0;
            end
        end else if (i_cmd.commit) begin
            case (r_req_type)
                REQ_GET: begin
                    if (hit_any) begin
                        if (r_slot_level[hit_idx] < r_level) begin
                            r_slot_level[hit_idx] <= r_level;
                        end
                        if (r_slot_refs[hit_idx] != REFS_MAX) begin
                            r_slot_refs[hit_idx] <= r_slot_refs[hit_idx] + 1'b1;
                        end
                    end else if (alloc_any) begin
                        r_slot_valid[alloc_idx] <= 1'b1;
                        r_slot_level[alloc_idx] <= r_level;
                        r_slot_refs[alloc_idx]  <= REFS_W'(1);
                    end
                end
                REQ_RELEASE: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (r_hit_vec[s] && (r_slot_refs[s] != '0)) begin
                            r_slot_refs[s] <= r_slot_refs[s] - 1'b1;
                        end
                    end
                end
                REQ_CLEAR: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        r_slot_valid[s] <= 1'b0;
                        r_slot_level[s] <= '0;
                        r_slot_refs[s]  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // tag written on allocation
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_req_type == REQ_GET) && !hit_any && alloc_any) begin
            r_slot_tag[alloc_idx] <= r_tag;
        end
    end

    // result of the committing item
    always_comb begin
        n_out_item.status     = ST_CLEARED;
        n_out_item.slot_index = '0;
        case (r_req_type)
            REQ_GET: begin
                if (hit_any) begin
                    n_out_item.status     = ST_HIT;
                    n_out_item.slot_index = IDX_W'(hit_idx);
                end else if (alloc_any) begin
                    n_out_item.status     = ST_MISS;
                    n_out_item.slot_index = IDX_W'(alloc_idx);
                end else begin
                    n_out_item.status = ST_FULL;
                end
            end
            REQ_RELEASE: begin
                n_out_item.status = ST_RELEASED;
            end
            default: begin
                n_out_item.status = ST_CLEARED;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && (r_req_type != REQ_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_req_type != REQ_NONE)) begin
            r_out_item <= n_out_item;
        end
    end

    // commit waits only for room in the output register
    assign o_sts.commit_ok = (r_req_type == REQ_NONE) || !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/refcounted_block_cache_directory.sv -----
// refcounted_block_cache_directory: top level of the reference-counted cache directory
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one request item:
// get a block, release a block, or clear the whole directory. Output channel
// (o_out_valid / i_out_ready / o_out_item) returns one result item per request
// (hit, miss with slot allocated, full, released, cleared); request type three
// is dropped with no result.
// One item is in flight at a time: capture, then a look-up state of parallel tag
// compare and victim level search over all slots, then a commit state that
// updates a slot and loads the output register.
// The next item is accepted in the commit cycle of the current one, while its
// result waits in the output register. If the receiver stalls with a result
// still held, the following item stays in its commit cycle until the register
// frees, and no further item is accepted meanwhile.
// Synchronous reset (i_rst_n low) empties the directory at once: all slots
// invalid with level and count zero, no result pending. No clearing pass.
`timescale 1ns / 1ps

module refcounted_block_cache_directory #(
    parameter int SLOTS     = 16,
    parameter int TOP_LEVEL = 5,
    parameter int TAG_BITS  = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rbcd_pkg::t_req_item i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rbcd_pkg::t_rsp_item o_out_item
);
    import rbcd_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    rbcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // directory datapath
    rbcd_dpath #(
        .SLOTS     (SLOTS),
        .TOP_LEVEL (TOP_LEVEL),
        .TAG_BITS  (TAG_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
